@@ rtl/core/lwbr_pkg.sv @@
// Package for the longest bounded-range window block: sizes, word types and FSM states.
// Used by every module in rtl/core; depends on nothing.
`timescale 1ns / 1ps
package lwbr_pkg;
    localparam int MaxLen = 4096;
    localparam int IdxW = $clog2(MaxLen);
    localparam int PosW = IdxW + 1;
    localparam int OutW = 13;
    localparam int DataW = 32;

    // One input word, as handed from the front end to the back end.
    typedef struct packed {
        logic signed [DataW-1:0] sample;
        logic                    first;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAXPOP,
        ST_MINPOP,
        ST_RANGE,
        ST_TRIM,
        ST_DONE
    } be_state_t;
endpackage

@@ rtl/core/longest_window_bounded_range_top.sv @@
// Longest bounded-range window: each accepted word yields one result word. The back
// end takes a word from the front queue once it is idle; its result word follows the
// queue pops and window trim steps, each paced by the back end's two-stage registered
// memory reads. Words beyond 4096 per run give a result word with overflow set. The
// next word starts only once the result word has been taken, so a word queued behind
// earlier ones waits for them as well.
// Top level; depends on lwbr_pkg, lwbr_front and lwbr_back.
`timescale 1ns / 1ps
module longest_window_bounded_range_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample
    input  logic        s_tuser,   // first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // best_start[12:0], best_end[25:13], zero fill
    output logic        m_tuser    // overflow
);
    import lwbr_pkg::*;

    logic [31:0] limit_reg;
    item_t s_item, q_item;
    logic q_valid, q_ready;
    logic [OutW-1:0] bs, be;

    // Range limit register.
    always_ff @(posedge aclk) begin
        if (!aresetn) limit_reg <= '0;
        else if (cfg_wr_en) limit_reg <= cfg_wr_data;
    end

    assign s_item.sample = s_tdata;
    assign s_item.first  = s_tuser;

    lwbr_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_item(s_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    lwbr_back u_back (
        .aclk(aclk), .aresetn(aresetn), .range_limit(limit_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_best_start(bs),
        .m_best_end(be), .m_overflow(m_tuser)
    );

    assign m_tdata = {6'd0, be, bs};
endmodule

@@ rtl/core/lwbr_front.sv @@
// Front end: accepts input words into a two-entry queue for the back end.
// Depends on lwbr_pkg.
`timescale 1ns / 1ps
module lwbr_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  lwbr_pkg::item_t s_item,
    output logic            q_valid,
    input  logic            q_ready,
    output lwbr_pkg::item_t q_item
);
    import lwbr_pkg::*;

    item_t     buf_reg [2];
    logic      wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = buf_reg[rp_reg];

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) buf_reg[wp_reg] <= s_item;
    end

    // Queue pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (s_tvalid && s_tready) wp_reg <= ~wp_reg;
            if (q_valid && q_ready) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, s_tvalid && s_tready} - {1'b0, q_valid && q_ready};
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg != 2'd3)
        else $error("front queue count out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !q_valid) else $error("empty queue shows valid");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2 && !(q_valid && q_ready)) |=> cnt_reg == 2'd2)
        else $error("full queue lost a word");
endmodule

@@ rtl/core/lwbr_back.sv @@
// Back end: sample store, monotonic min/max index queues and window search.
// Depends on lwbr_pkg.
`timescale 1ns / 1ps
module lwbr_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [31:0]                 range_limit,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  lwbr_pkg::item_t             q_item,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [lwbr_pkg::OutW-1:0]   m_best_start,
    output logic [lwbr_pkg::OutW-1:0]   m_best_end,
    output logic                        m_overflow
);
    import lwbr_pkg::*;

    // Memories with registered read ports.
    logic signed [DataW-1:0] smem [MaxLen];
    logic [IdxW-1:0]         xq [MaxLen];
    logic [IdxW-1:0]         nq [MaxLen];

    be_state_t state_reg, state_next;
    logic signed [DataW-1:0] x_reg;
    logic [PosW-1:0] pos_reg, pos_next;
    logic [IdxW-1:0] p_reg;
    logic [PosW-1:0] xh_reg, xh_next, xt_reg, xt_next, nh_reg, nh_next, nt_reg, nt_next;
    logic [IdxW-1:0] ws_reg, ws_next, bs_reg, bs_next, be_reg, be_next;
    logic            ov_reg;
    logic            out_v_reg;
    // Queue read addresses, queue entries and the samples they point to.
    logic [IdxW-1:0] xq_raddr, nq_raddr;
    logic [IdxW-1:0] xq_rd, nq_rd;
    logic signed [DataW-1:0] sa_rd, sb_rd;
    logic            take;

    // Helper: two-step read: queue index then sample.
    logic [1:0] ph_reg, ph_next;

    always_ff @(posedge aclk) begin
        xq_rd <= xq[xq_raddr];
        nq_rd <= nq[nq_raddr];
        sa_rd <= smem[xq_rd];
        sb_rd <= smem[nq_rd];
    end

    logic wr_s, wr_x, wr_n;
    logic [IdxW-1:0] wx_addr, wn_addr;
    always_ff @(posedge aclk) begin
        if (wr_s) smem[p_reg] <= x_reg;
        if (wr_x) xq[wx_addr] <= p_reg;
        if (wr_n) nq[wn_addr] <= p_reg;
    end

    logic signed [DataW:0] diff;
    assign diff = {sa_rd[DataW-1], sa_rd} - {sb_rd[DataW-1], sb_rd};
    logic [PosW-1:0] xtm1, ntm1;
    assign xtm1 = xt_reg - 1'b1;
    assign ntm1 = nt_reg - 1'b1;

    assign take    = q_valid && q_ready;
    assign q_ready = (state_reg == ST_IDLE) && !out_v_reg;
    assign m_tvalid = out_v_reg;
    assign m_best_start = OutW'({1'b0, bs_reg} + 1'b1);
    assign m_best_end   = OutW'({1'b0, be_reg} + 1'b1);
    assign m_overflow   = ov_reg;

    // Next state and datapath control.
    always_comb begin
        state_next = state_reg;
        ph_next = ph_reg;
        pos_next = pos_reg;
        xh_next = xh_reg; xt_next = xt_reg; nh_next = nh_reg; nt_next = nt_reg;
        ws_next = ws_reg; bs_next = bs_reg; be_next = be_reg;
        wr_s = 1'b0; wr_x = 1'b0; wr_n = 1'b0;
        wx_addr = xt_reg[IdxW-1:0]; wn_addr = nt_reg[IdxW-1:0];
        xq_raddr = xtm1[IdxW-1:0];
        nq_raddr = ntm1[IdxW-1:0];
        case (state_reg)
            ST_IDLE: begin
                ph_next = 2'd0;
            end
            ST_MAXPOP: begin
                xq_raddr = xtm1[IdxW-1:0];
                if (xt_reg <= xh_reg) begin
                    wr_x = 1'b1; xt_next = xt_reg + 1'b1;
                    ph_next = 2'd0; state_next = ST_MINPOP;
                end else if (ph_reg != 2'd2) ph_next = ph_reg + 1'b1;
                else if (sa_rd <= x_reg) begin
                    xt_next = xtm1; ph_next = 2'd0;
                end else begin
                    wr_x = 1'b1; xt_next = xt_reg + 1'b1;
                    ph_next = 2'd0; state_next = ST_MINPOP;
                end
            end
            ST_MINPOP: begin
                nq_raddr = ntm1[IdxW-1:0];
                if (nt_reg <= nh_reg) begin
                    wr_n = 1'b1; nt_next = nt_reg + 1'b1;
                    ph_next = 2'd0; state_next = ST_RANGE;
                end else if (ph_reg != 2'd2) ph_next = ph_reg + 1'b1;
                else if (sb_rd >= x_reg) begin
                    nt_next = ntm1; ph_next = 2'd0;
                end else begin
                    wr_n = 1'b1; nt_next = nt_reg + 1'b1;
                    ph_next = 2'd0; state_next = ST_RANGE;
                end
            end
            ST_RANGE: begin
                // Read both queue heads, then compare the range.
                xq_raddr = xh_reg[IdxW-1:0];
                nq_raddr = nh_reg[IdxW-1:0];
                if (ws_reg >= p_reg) state_next = ST_DONE;
                else if (ph_reg != 2'd2) ph_next = ph_reg + 1'b1;
                else if (diff > $signed({1'b0, range_limit})) begin
                    ws_next = ws_reg + 1'b1; ph_next = 2'd0; state_next = ST_TRIM;
                end else state_next = ST_DONE;
            end
            ST_TRIM: begin
                // Drop head entries now left of the window start.
                xq_raddr = xh_reg[IdxW-1:0];
                nq_raddr = nh_reg[IdxW-1:0];
                if (ph_reg != 2'd1) ph_next = ph_reg + 1'b1;
                else begin
                    ph_next = 2'd0;
                    if (xt_reg > xh_reg && xq_rd < ws_reg) xh_next = xh_reg + 1'b1;
                    if (nt_reg > nh_reg && nq_rd < ws_reg) nh_next = nh_reg + 1'b1;
                    if (!((xt_reg > xh_reg && xq_rd < ws_reg) ||
                          (nt_reg > nh_reg && nq_rd < ws_reg)))
                        state_next = ST_RANGE;
                end
            end
            ST_DONE: begin
                if (p_reg == '0 || (p_reg - ws_reg) > (be_reg - bs_reg)) begin
                    bs_next = ws_reg; be_next = p_reg;
                end
                pos_next = {1'b0, p_reg} + 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        if (state_reg == ST_IDLE && take) begin
            if (q_item.first) begin
                xh_next = '0; xt_next = '0; nh_next = '0; nt_next = '0;
                ws_next = '0; bs_next = '0; be_next = '0; pos_next = '0;
            end
            if (!q_item.first && pos_reg >= PosW'(MaxLen)) state_next = ST_IDLE;
            else state_next = ST_MAXPOP;
        end
        if (state_reg == ST_MAXPOP && ph_reg == 2'd0 && xt_reg == xh_reg) wr_s = 1'b1;
        if (state_reg == ST_MAXPOP && ph_reg == 2'd0) wr_s = 1'b1;
    end

    // State and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE; ph_reg <= 2'd0; pos_reg <= '0;
            xh_reg <= '0; xt_reg <= '0; nh_reg <= '0; nt_reg <= '0;
            ws_reg <= '0; bs_reg <= '0; be_reg <= '0;
            out_v_reg <= 1'b0; ov_reg <= 1'b0;
        end else begin
            state_reg <= state_next; ph_reg <= ph_next; pos_reg <= pos_next;
            xh_reg <= xh_next; xt_reg <= xt_next; nh_reg <= nh_next; nt_reg <= nt_next;
            ws_reg <= ws_next; bs_reg <= bs_next; be_reg <= be_next;
            if (state_reg == ST_DONE) begin
                out_v_reg <= 1'b1; ov_reg <= 1'b0;
            end else if (state_reg == ST_IDLE && take && state_next == ST_IDLE) begin
                out_v_reg <= 1'b1; ov_reg <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // Sample and its position are payload.
    always_ff @(posedge aclk) begin
        if (take) begin
            x_reg <= q_item.sample;
            p_reg <= q_item.first ? '0 : pos_reg[IdxW-1:0];
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !q_ready) else $error("accepted while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        xh_reg <= xt_reg) else $error("max queue head past tail");
    assert property (@(posedge aclk) disable iff (!aresetn)
        nh_reg <= nt_reg) else $error("min queue head past tail");
    assert property (@(posedge aclk) disable iff (!aresetn)
        bs_reg <= be_reg) else $error("best window reversed");
endmodule
